// ===== rtl/core/phpc_pkg.sv =====
package phpc_pkg;

  // Default sample width of the converter readings and calibration bounds
  localparam int unsigned SAMPLE_BITS = 12;

  // Calibration register file
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CAL_RESET = 999;

  localparam logic [REG_IDX_W-1:0] REG_LOW_AT_4  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_AT_4 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_AT_5  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_AT_5 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOW_AT_6  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_AT_6 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LOW_AT_7  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_AT_7 = 3'd7;

  // Windows and the interpolation quotient
  localparam int unsigned NUM_WIN   = 4;
  localparam int unsigned WIN_IDX_W = 2;
  localparam int unsigned QUOT_W    = 4;
  localparam int unsigned EXTRA_W   = 4;  // headroom for ten times a difference

  // Result codes
  localparam int unsigned PH_W = 7;
  localparam logic [PH_W-1:0] PH_FIRST_WIN = 7'd40;
  localparam logic [PH_W-1:0] PH_STEP      = 7'd10;
  localparam logic [PH_W-1:0] PH_BELOW_7   = 7'd80;
  localparam logic [PH_W-1:0] PH_ABOVE_4   = 7'd30;
  localparam logic [PH_W-1:0] PH_NONE      = 7'd0;

  // Classification flags handed along the chain
  typedef struct packed {
    logic                 win_hit;
    logic [WIN_IDX_W-1:0] win_idx;
    logic                 gap_hit;
    logic [WIN_IDX_W-1:0] gap_idx;
    logic                 below;
    logic                 above;
    logic [QUOT_W-1:0]    quot;
  } phpc_ctl_t;

  // pH in tenths at the centre of a window
  function automatic logic [PH_W-1:0] ph_base(input logic [WIN_IDX_W-1:0] idx);
    logic [PH_W-1:0] base;
    unique case (idx)
      2'd0:    base = PH_FIRST_WIN;
      2'd1:    base = PH_FIRST_WIN + PH_STEP;
      2'd2:    base = PH_FIRST_WIN + 7'(2 * PH_STEP);
      default: base = PH_FIRST_WIN + 7'(3 * PH_STEP);
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/core/ph_piecewise_calibration.sv =====
// pH calibration lookup. Each reading_i transaction yields one result
// transaction carrying pH in tenths (ph_tenths_o) and a flag (valid_res_o)
// that is low when no rule matches because the calibration is misordered.
// Four calibration windows (pH 4 to 7) are written through the cfg_* port,
// indexes 0..7 = low/high of pH 4, 5, 6, 7, all reset to 999. A reading in a
// window gives its centre value; a reading between two windows is
// interpolated with a floored quotient; below the pH 7 window gives 80 and
// above the pH 4 window 30. The datapath is a chain of nine register stages:
// four window cells, one per calibration window, then four divider cells that
// each resolve one bit of the interpolation quotient, then the output
// register. One new reading is taken every cycle while the output is not
// stalled, and every stage that holds a bubble still accepts while a result
// waits. Write configuration only while the chain is empty.
module ph_piecewise_calibration #(
  parameter int unsigned SampleBits = phpc_pkg::SAMPLE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [SampleBits-1:0]            reading_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [phpc_pkg::PH_W-1:0]        ph_tenths_o,
  output logic                             valid_res_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [phpc_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [SampleBits-1:0]            cfg_data_i
);
  import phpc_pkg::*;

  localparam int unsigned RemW     = SampleBits + EXTRA_W;
  localparam int unsigned NumStage = NUM_WIN + QUOT_W;

  // Calibration registers
  logic [SampleBits-1:0] cal_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cal_q[i] <= SampleBits'(CAL_RESET);
      end
    end else if (cfg_we_i) begin
      cal_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Window bounds per cell; the last window has no gap after it
  logic [SampleBits-1:0] win_lo [NUM_WIN];
  logic [SampleBits-1:0] win_hi [NUM_WIN];
  logic [SampleBits-1:0] win_hn [NUM_WIN];

  always_comb begin
    win_lo[0] = cal_q[REG_LOW_AT_4];
    win_lo[1] = cal_q[REG_LOW_AT_5];
    win_lo[2] = cal_q[REG_LOW_AT_6];
    win_lo[3] = cal_q[REG_LOW_AT_7];
    win_hi[0] = cal_q[REG_HIGH_AT_4];
    win_hi[1] = cal_q[REG_HIGH_AT_5];
    win_hi[2] = cal_q[REG_HIGH_AT_6];
    win_hi[3] = cal_q[REG_HIGH_AT_7];
    win_hn[0] = win_hi[1];
    win_hn[1] = win_hi[2];
    win_hn[2] = win_hi[3];
    win_hn[3] = '0;
  end

  // Chain nodes: node 0 is the input, node k the output of cell k-1
  logic [NumStage:0]     node_valid;
  logic [NumStage:0]     node_ready;
  logic [SampleBits-1:0] node_rd  [NUM_WIN+1];
  logic [RemW-1:0]       node_rem [NumStage];
  logic [SampleBits-1:0] node_den [NumStage];
  phpc_ctl_t             node_ctl [NumStage+1];

  assign node_valid[0] = in_valid_i;
  assign in_stall_o    = !node_ready[0];
  assign node_rd[0]    = reading_i;
  assign node_rem[0]   = '0;
  assign node_den[0]   = '0;
  assign node_ctl[0]   = '0;

  for (genvar w = 0; w < NUM_WIN; w++) begin : g_win
    phpc_win_cell #(
      .SampleBits (SampleBits),
      .WinIdx     (w)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (node_valid[w]),
      .in_ready_o  (node_ready[w]),
      .reading_i   (node_rd[w]),
      .rem_i       (node_rem[w]),
      .den_i       (node_den[w]),
      .ctl_i       (node_ctl[w]),
      .lo_i        (win_lo[w]),
      .hi_i        (win_hi[w]),
      .hi_next_i   (win_hn[w]),
      .out_valid_o (node_valid[w+1]),
      .out_ready_i (node_ready[w+1]),
      .reading_o   (node_rd[w+1]),
      .rem_o       (node_rem[w+1]),
      .den_o       (node_den[w+1]),
      .ctl_o       (node_ctl[w+1])
    );
  end

  // Divider cells resolve the quotient from its top bit down
  for (genvar d = 0; d < QUOT_W; d++) begin : g_div
    localparam int unsigned N = NUM_WIN + d;
    if (d < QUOT_W - 1) begin : g_mid
      phpc_div_cell #(
        .SampleBits (SampleBits),
        .QuotBit    (QUOT_W - 1 - d)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .in_valid_i  (node_valid[N]),
        .in_ready_o  (node_ready[N]),
        .rem_i       (node_rem[N]),
        .den_i       (node_den[N]),
        .ctl_i       (node_ctl[N]),
        .out_valid_o (node_valid[N+1]),
        .out_ready_i (node_ready[N+1]),
        .rem_o       (node_rem[N+1]),
        .den_o       (node_den[N+1]),
        .ctl_o       (node_ctl[N+1])
      );
    end else begin : g_last
      phpc_div_cell #(
        .SampleBits (SampleBits),
        .QuotBit    (QUOT_W - 1 - d)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .in_valid_i  (node_valid[N]),
        .in_ready_o  (node_ready[N]),
        .rem_i       (node_rem[N]),
        .den_i       (node_den[N]),
        .ctl_i       (node_ctl[N]),
        .out_valid_o (node_valid[N+1]),
        .out_ready_i (node_ready[N+1]),
        .rem_o       (),
        .den_o       (),
        .ctl_o       (node_ctl[N+1])
      );
    end
  end

  // Resolve the rules in priority order: window, gap, below pH 7, above pH 4
  phpc_ctl_t       ctl_f;
  logic [PH_W-1:0] ph_d, ph_q;
  logic            vres_d, vres_q;
  logic            out_valid_q;

  assign ctl_f = node_ctl[NumStage];

  always_comb begin
    priority if (ctl_f.win_hit) begin
      ph_d   = ph_base(ctl_f.win_idx);
      vres_d = 1'b1;
    end else if (ctl_f.gap_hit) begin
      ph_d   = ph_base(ctl_f.gap_idx) + PH_W'(ctl_f.quot);
      vres_d = 1'b1;
    end else if (ctl_f.below) begin
      ph_d   = PH_BELOW_7;
      vres_d = 1'b1;
    end else if (ctl_f.above) begin
      ph_d   = PH_ABOVE_4;
      vres_d = 1'b1;
    end else begin
      ph_d   = PH_NONE;
      vres_d = 1'b0;
    end
  end

  // Output register: hold the result while the consumer stalls
  assign node_ready[NumStage] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (node_ready[NumStage]) begin
      out_valid_q <= node_valid[NumStage];
    end
  end

  always_ff @(posedge clk_i) begin
    if (node_ready[NumStage] && node_valid[NumStage]) begin
      ph_q   <= ph_d;
      vres_q <= vres_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ph_tenths_o = ph_q;
  assign valid_res_o = vres_q;

  // An unmatched reading must report no pH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (ph_tenths_o == PH_NONE))
    else $error("unmatched result carries a nonzero pH");

  // A matched result stays within pH 3.0 to 8.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      (ph_tenths_o >= PH_ABOVE_4 && ph_tenths_o <= PH_BELOW_7))
    else $error("matched result outside the calibrated range");

  // Back-pressure reaches the input only when every stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |->
      (out_valid_o && out_stall_i && (&node_valid[NumStage:1])))
    else $error("input stalled while the chain holds a bubble");

endmodule

// ===== rtl/core/phpc_win_cell.sv =====
module phpc_win_cell #(
  parameter int unsigned SampleBits = phpc_pkg::SAMPLE_BITS,
  parameter int unsigned WinIdx     = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [SampleBits-1:0]                  reading_i,
  input  logic [SampleBits+phpc_pkg::EXTRA_W-1:0] rem_i,
  input  logic [SampleBits-1:0]                  den_i,
  input  phpc_pkg::phpc_ctl_t                    ctl_i,
  input  logic [SampleBits-1:0]                  lo_i,
  input  logic [SampleBits-1:0]                  hi_i,
  input  logic [SampleBits-1:0]                  hi_next_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [SampleBits-1:0]                  reading_o,
  output logic [SampleBits+phpc_pkg::EXTRA_W-1:0] rem_o,
  output logic [SampleBits-1:0]                  den_o,
  output phpc_pkg::phpc_ctl_t                    ctl_o
);
  import phpc_pkg::*;

  localparam int unsigned RemW    = SampleBits + EXTRA_W;
  localparam bit          HasGap  = (WinIdx < NUM_WIN - 1);
  localparam bit          IsFirst = (WinIdx == 0);
  localparam bit          IsLast  = (WinIdx == NUM_WIN - 1);

  logic                  valid_q;
  logic [SampleBits-1:0] reading_q;
  logic [RemW-1:0]       rem_d, rem_q;
  logic [SampleBits-1:0] den_d, den_q;
  phpc_ctl_t             ctl_d, ctl_q;
  logic                  in_win, in_gap;
  logic [SampleBits-1:0] diff;
  logic [RemW-1:0]       diff_x;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    in_win = (reading_i >= lo_i) && (reading_i <= hi_i);
    in_gap = HasGap && (reading_i > hi_next_i) && (reading_i < lo_i);
    diff   = lo_i - reading_i;
    diff_x = RemW'(diff);
    ctl_d  = ctl_i;
    rem_d  = rem_i;
    den_d  = den_i;
    if (!ctl_i.win_hit && in_win) begin
      ctl_d.win_hit = 1'b1;
      ctl_d.win_idx = WIN_IDX_W'(WinIdx);
    end
    if (!ctl_i.gap_hit && in_gap) begin
      ctl_d.gap_hit = 1'b1;
      ctl_d.gap_idx = WIN_IDX_W'(WinIdx);
      rem_d         = (diff_x << 3) + (diff_x << 1);
      den_d         = lo_i - hi_next_i;
    end
    if (IsFirst) begin
      ctl_d.above = reading_i > hi_i;
    end
    if (IsLast) begin
      ctl_d.below = reading_i < lo_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      reading_q <= reading_i;
      rem_q     <= rem_d;
      den_q     <= den_d;
      ctl_q     <= ctl_d;
    end
  end

  assign out_valid_o = valid_q;
  assign reading_o   = reading_q;
  assign rem_o       = rem_q;
  assign den_o       = den_q;
  assign ctl_o       = ctl_q;

endmodule

// ===== rtl/core/phpc_div_cell.sv =====
module phpc_div_cell #(
  parameter int unsigned SampleBits = phpc_pkg::SAMPLE_BITS,
  parameter int unsigned QuotBit    = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [SampleBits+phpc_pkg::EXTRA_W-1:0] rem_i,
  input  logic [SampleBits-1:0]                  den_i,
  input  phpc_pkg::phpc_ctl_t                    ctl_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [SampleBits+phpc_pkg::EXTRA_W-1:0] rem_o,
  output logic [SampleBits-1:0]                  den_o,
  output phpc_pkg::phpc_ctl_t                    ctl_o
);
  import phpc_pkg::*;

  localparam int unsigned RemW = SampleBits + EXTRA_W;

  logic                  valid_q;
  logic [RemW-1:0]       trial;
  logic                  fits;
  logic [RemW-1:0]       rem_d, rem_q;
  logic [SampleBits-1:0] den_q;
  phpc_ctl_t             ctl_d, ctl_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // One restoring step: try the shifted divisor, keep the remainder if it fits
  always_comb begin
    trial = RemW'(den_i) << QuotBit;
    fits  = rem_i >= trial;
    rem_d = fits ? (rem_i - trial) : rem_i;
    ctl_d = ctl_i;
    ctl_d.quot[QuotBit] = fits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      ctl_q <= ctl_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign den_o       = den_q;
  assign ctl_o       = ctl_q;

endmodule
